[design/ifp_pkg.sv]
// Shared types, operator codes and the operator priority table of the infix-to-postfix converter.
package ifp_pkg;

    // Width of an operator table index
    localparam int unsigned CODE_BITS = 5;
    // Width of an operator priority
    localparam int unsigned PRIO_BITS = 4;
    // Number of operators in the table
    localparam logic [CODE_BITS-1:0] NUM_OPS = 5'd29;

    // Operator codes with special handling
    localparam logic [CODE_BITS-1:0] OP_LPAREN = 5'd0;
    localparam logic [CODE_BITS-1:0] OP_RPAREN = 5'd1;
    localparam logic [CODE_BITS-1:0] OP_COMMA  = 5'd2;
    localparam logic [CODE_BITS-1:0] OP_MUL    = 5'd3;
    localparam logic [CODE_BITS-1:0] OP_MOD    = 5'd5;
    localparam logic [CODE_BITS-1:0] OP_ADD    = 5'd6;
    localparam logic [CODE_BITS-1:0] OP_SUB    = 5'd7;

    // Priority levels
    localparam logic [PRIO_BITS-1:0] PRIO_FUNC  = 4'd10;
    localparam logic [PRIO_BITS-1:0] PRIO_MUL   = 4'd9;
    localparam logic [PRIO_BITS-1:0] PRIO_ADD   = 4'd8;
    localparam logic [PRIO_BITS-1:0] PRIO_COMMA = 4'd0;

    // Kind of a result beat
    typedef enum logic [1:0] {
        KIND_OPERAND  = 2'd0,
        KIND_OPERATOR = 2'd1,
        KIND_END      = 2'd2
    } t_kind;

    // Priority of an operator code: parentheses and functions bind tightest, comma loosest
    function automatic logic [PRIO_BITS-1:0] op_priority(input logic [CODE_BITS-1:0] code);
        logic [PRIO_BITS-1:0] prio;
        begin
            if (code == OP_COMMA) begin
                prio = PRIO_COMMA;
            end else if (code >= OP_MUL && code <= OP_MOD) begin
                prio = PRIO_MUL;
            end else if (code == OP_ADD || code == OP_SUB) begin
                prio = PRIO_ADD;
            end else begin
                prio = PRIO_FUNC;
            end
            return prio;
        end
    endfunction

endpackage

[design/infix_to_postfix_converter_core.sv]
// Infix-to-postfix converter: operator stack, pop sequencer and registered output stage.
// Every result passes through a pending register, which decides tlast, before the output
// register. Items are taken one at a time: a new item is accepted only in the idle state,
// and output stalls can hold the sequencer. Synchronous active-low reset empties the stack.
module infix_to_postfix_converter_core
    import ifp_pkg::*;
#(
    parameter int unsigned STACK_DEPTH     = 16,
    parameter int unsigned OPERAND_ID_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Input stream
    input  logic                                         i_s_axis_tvalid,
    output logic                                         o_s_axis_tready,
    // tdata: operator_code [4:0], operand_id [OPERAND_ID_BITS+4:5], zero pad above
    input  logic [((CODE_BITS+OPERAND_ID_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: cmd [0], token_is_operator [1]
    input  logic [1:0]                                   i_s_axis_tuser,
    // Output stream
    output logic                                         o_m_axis_tvalid,
    input  logic                                         i_m_axis_tready,
    // tdata: out_operator [4:0], out_operand [OPERAND_ID_BITS+4:5],
    //        overflow [OPERAND_ID_BITS+5], zero pad above
    output logic [((CODE_BITS+OPERAND_ID_BITS+8)/8)*8-1:0] o_m_axis_tdata,
    // tuser: out_kind [1:0]
    output logic [1:0]                                   o_m_axis_tuser,
    output logic                                         o_m_axis_tlast
);

    localparam int unsigned CNT_BITS  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ADDR_BITS = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_TEST,
        S_PUSH,
        S_END,
        S_FINISH
    } t_state;

    // Operator stack
    logic [CODE_BITS-1:0] r_stack [STACK_DEPTH];
    logic [CODE_BITS-1:0] r_rd;

    // Control and item registers
    t_state                r_state, n_state;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic                  r_ovf, n_ovf;
    logic                  r_cmd, n_cmd;
    logic [CODE_BITS-1:0]  r_code, n_code;

    // Pending result, held until it is known whether it is the last one
    logic                       r_pend_valid, n_pend_valid;
    t_kind                      r_pend_kind, n_pend_kind;
    logic [CODE_BITS-1:0]       r_pend_op, n_pend_op;
    logic [OPERAND_ID_BITS-1:0] r_pend_operand, n_pend_operand;
    logic                       r_pend_ovf, n_pend_ovf;

    // Output register
    logic                       r_out_valid, n_out_valid;
    t_kind                      r_out_kind, n_out_kind;
    logic [CODE_BITS-1:0]       r_out_op, n_out_op;
    logic [OPERAND_ID_BITS-1:0] r_out_operand, n_out_operand;
    logic                       r_out_ovf, n_out_ovf;
    logic                       r_out_last, n_out_last;

    logic                       accept;
    logic                       out_free;
    logic                       can_emit;
    logic                       emit;
    t_kind                      emit_kind;
    logic [CODE_BITS-1:0]       emit_op;
    logic                       pop;
    logic                       mem_we;
    logic [CODE_BITS-1:0]       in_code;
    logic [OPERAND_ID_BITS-1:0] in_operand;
    logic                       count_one;
    t_state                     test_next;

    assign accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign can_emit   = !r_pend_valid || out_free;
    assign in_code    = i_s_axis_tdata[CODE_BITS-1:0];
    assign in_operand = i_s_axis_tdata[CODE_BITS +: OPERAND_ID_BITS];
    assign count_one  = (r_count == CNT_BITS'(1));

    // Decide the pop of the entry read from the top of the stack
    always_comb begin
        pop       = 1'b0;
        test_next = S_READ;
        if (r_cmd) begin
            pop       = 1'b1;
            test_next = count_one ? S_END : S_READ;
        end else if (r_code == OP_RPAREN) begin
            pop       = 1'b1;
            test_next = (r_rd == OP_LPAREN || count_one) ? S_FINISH : S_READ;
        end else if (r_rd == OP_LPAREN || op_priority(r_rd) < op_priority(r_code)) begin
            test_next = S_PUSH;
        end else begin
            pop       = 1'b1;
            test_next = count_one ? S_PUSH : S_READ;
        end
    end

    // Sequencer next state, stack pointer, pending and output registers
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_ovf          = r_ovf;
        n_cmd          = r_cmd;
        n_code         = r_code;
        n_pend_valid   = r_pend_valid;
        n_pend_kind    = r_pend_kind;
        n_pend_op      = r_pend_op;
        n_pend_operand = r_pend_operand;
        n_pend_ovf     = r_pend_ovf;
        n_out_valid    = r_out_valid;
        n_out_kind     = r_out_kind;
        n_out_op       = r_out_op;
        n_out_operand  = r_out_operand;
        n_out_ovf      = r_out_ovf;
        n_out_last     = r_out_last;
        emit           = 1'b0;
        emit_kind      = KIND_OPERATOR;
        emit_op        = r_rd;
        mem_we         = 1'b0;

        // Drop the output beat once taken
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd  = i_s_axis_tuser[0];
                    n_code = in_code;
                    if (i_s_axis_tuser[0]) begin
                        n_state = (r_count != '0) ? S_READ : S_END;
                    end else if (!i_s_axis_tuser[1]) begin
                        n_pend_valid   = 1'b1;
                        n_pend_kind    = KIND_OPERAND;
                        n_pend_op      = '0;
                        n_pend_operand = in_operand;
                        n_pend_ovf     = r_ovf;
                        n_state        = S_FINISH;
                    end else if (in_code >= NUM_OPS) begin
                        n_state = S_IDLE;
                    end else if (in_code == OP_LPAREN) begin
                        n_state = S_PUSH;
                    end else if (r_count != '0) begin
                        n_state = S_READ;
                    end else begin
                        n_state = (in_code == OP_RPAREN) ? S_FINISH : S_PUSH;
                    end
                end
            end
            S_READ: begin
                n_state = S_TEST;
            end
            S_TEST: begin
                if (!(pop && r_rd > OP_COMMA) || can_emit) begin
                    if (pop) begin
                        n_count = r_count - 1'b1;
                    end
                    emit    = pop && (r_rd > OP_COMMA);
                    n_state = test_next;
                end
            end
            S_PUSH: begin
                if (r_code != OP_COMMA) begin
                    if (r_count < CNT_BITS'(STACK_DEPTH)) begin
                        mem_we  = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                n_state = S_FINISH;
            end
            S_END: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_kind = KIND_END;
                    emit_op   = '0;
                    n_ovf     = 1'b0;
                    n_state   = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_kind    = r_pend_kind;
                    n_out_op      = r_pend_op;
                    n_out_operand = r_pend_operand;
                    n_out_ovf     = r_pend_ovf;
                    n_out_last    = 1'b1;
                    n_pend_valid  = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Advance the pending result to the output, then hold the new one
        if (emit) begin
            if (r_pend_valid) begin
                n_out_valid   = 1'b1;
                n_out_kind    = r_pend_kind;
                n_out_op      = r_pend_op;
                n_out_operand = r_pend_operand;
                n_out_ovf     = r_pend_ovf;
                n_out_last    = 1'b0;
            end
            n_pend_valid   = 1'b1;
            n_pend_kind    = emit_kind;
            n_pend_op      = emit_op;
            n_pend_operand = '0;
            n_pend_ovf     = r_ovf;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_ovf        <= n_ovf;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_cmd          <= n_cmd;
        r_code         <= n_code;
        r_pend_kind    <= n_pend_kind;
        r_pend_op      <= n_pend_op;
        r_pend_operand <= n_pend_operand;
        r_pend_ovf     <= n_pend_ovf;
        r_out_kind     <= n_out_kind;
        r_out_op       <= n_out_op;
        r_out_operand  <= n_out_operand;
        r_out_ovf      <= n_out_ovf;
        r_out_last     <= n_out_last;
    end

    // Stack memory: push at the count, registered read of the top entry
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[r_count[ADDR_BITS-1:0]] <= r_code;
        end
        if (r_state == S_READ) begin
            r_rd <= r_stack[ADDR_BITS'(r_count - 1'b1)];
        end
    end

    // Drive the ports
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    always_comb begin
        o_m_axis_tdata                                = '0;
        o_m_axis_tdata[CODE_BITS-1:0]                 = r_out_op;
        o_m_axis_tdata[CODE_BITS +: OPERAND_ID_BITS]  = r_out_operand;
        o_m_axis_tdata[CODE_BITS + OPERAND_ID_BITS]   = r_out_ovf;
    end

    // The stack count never passes the depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // No result is left pending when a new item may enter
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending result left behind at idle");

    // After the end marker the overflow flag is clear and the stack empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END && can_emit) |=> (!r_ovf && r_count == '0))
        else $error("state not cleared after end marker");

endmodule

[sim/infix_to_postfix_converter_core_tb.sv]
// Self-checking testbench of the infix-to-postfix converter core: tokens in, beats checked.
module infix_to_postfix_converter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ifp_pkg::*;

    localparam int unsigned DEPTH        = 16;
    localparam int unsigned ID_BITS      = 16;
    localparam int unsigned IN_W         = ((CODE_BITS + ID_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_W        = ((CODE_BITS + ID_BITS + 8) / 8) * 8;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned MAX_REPORTS  = 50;

    localparam logic [CODE_BITS-1:0] OP_DIV     = OP_MUL + 5'd1;
    localparam logic [CODE_BITS-1:0] FUNC_FIRST = OP_SUB + 5'd1;
    localparam logic [CODE_BITS-1:0] FUNC_LAST  = NUM_OPS - 5'd1;
    localparam logic [CODE_BITS-1:0] CODE_TOP   = '1;

    typedef struct packed {
        logic                 cmd;
        logic                 is_op;
        logic [CODE_BITS-1:0] code;
        logic [ID_BITS-1:0]   id;
    } t_token;

    typedef struct packed {
        t_kind                kind;
        logic [CODE_BITS-1:0] op;
        logic [ID_BITS-1:0]   id;
        logic                 ovf;
        logic                 last;
    } t_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // tdata: operator_code, operand_id, zero pad
    logic [IN_W-1:0]      i_s_axis_tdata  = '0;
    // tuser: cmd, token_is_operator
    logic [1:0]           i_s_axis_tuser  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // tdata: out_operator, out_operand, overflow, zero pad
    logic [OUT_W-1:0]     o_m_axis_tdata;
    // tuser: out_kind
    logic [1:0]           o_m_axis_tuser;
    logic                 o_m_axis_tlast;

    // Predicted converter state
    logic [CODE_BITS-1:0] op_stack [DEPTH];
    int unsigned          stack_fill = 0;
    logic                 ovf_seen   = 1'b0;

    t_beat  step_beats[$];
    t_beat  postfix_q[$];
    t_token pend_q[$];

    int unsigned fed_count    = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned tx_gap       = 0;
    int unsigned rx_gap       = 0;
    int unsigned hold_cnt     = 0;
    int unsigned hold_reqs    = 0;
    int unsigned hold_done    = 0;
    bit          idle_en      = 1'b0;

    infix_to_postfix_converter_core #(
        .STACK_DEPTH     (DEPTH),
        .OPERAND_ID_BITS (ID_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Binding strength of an operator; parentheses and functions are tightest
    function automatic logic [PRIO_BITS-1:0] bind_level(input logic [CODE_BITS-1:0] code);
        case (code)
            OP_COMMA:               return PRIO_COMMA;
            OP_MUL, OP_DIV, OP_MOD: return PRIO_MUL;
            OP_ADD, OP_SUB:         return PRIO_ADD;
            default:                return PRIO_FUNC;
        endcase
    endfunction

    task automatic add_beat(input t_kind kind, input logic [CODE_BITS-1:0] op,
                            input logic [ID_BITS-1:0] id);
        t_beat b;
        b.kind = kind;
        b.op   = op;
        b.id   = id;
        b.ovf  = ovf_seen;
        b.last = 1'b0;
        step_beats.push_back(b);
    endtask

    // Drop the top entry, emitting it unless it is a bracket
    task automatic pop_operator(output logic [CODE_BITS-1:0] popped);
        stack_fill--;
        popped = op_stack[stack_fill];
        if (popped > OP_COMMA) begin
            add_beat(KIND_OPERATOR, popped, '0);
        end
    endtask

    // Advance the predicted state by one token and queue the postfix beats it yields
    task automatic convert_token(input t_token t);
        logic [CODE_BITS-1:0] popped;
        logic                 stop;
        t_beat                b;
        step_beats.delete();
        if (t.cmd) begin
            while (stack_fill > 0) begin
                pop_operator(popped);
            end
            add_beat(KIND_END, '0, '0);
            ovf_seen = 1'b0;
        end else if (!t.is_op) begin
            add_beat(KIND_OPERAND, '0, t.id);
        end else if (t.code < NUM_OPS) begin
            stop = 1'b0;
            if (t.code == OP_RPAREN) begin
                // unwind to the matching bracket, or empty the stack if there is none
                while (stack_fill > 0 && !stop) begin
                    pop_operator(popped);
                    stop = (popped == OP_LPAREN);
                end
            end else begin
                if (t.code != OP_LPAREN) begin
                    while (stack_fill > 0 && !stop) begin
                        if (op_stack[stack_fill-1] == OP_LPAREN ||
                            bind_level(op_stack[stack_fill-1]) < bind_level(t.code)) begin
                            stop = 1'b1;
                        end else begin
                            pop_operator(popped);
                        end
                    end
                end
                // comma is never stacked; a full stack drops the push and flags it
                if (t.code != OP_COMMA) begin
                    if (stack_fill < DEPTH) begin
                        op_stack[stack_fill] = t.code;
                        stack_fill++;
                    end else begin
                        ovf_seen = 1'b1;
                    end
                end
            end
        end
        if (step_beats.size() > 0) begin
            b = step_beats.pop_back();
            b.last = 1'b1;
            step_beats.push_back(b);
        end
        while (step_beats.size() > 0) begin
            postfix_q.push_back(step_beats.pop_front());
        end
    endtask

    function automatic t_token make_token(input logic cmd, input logic is_op,
                                          input logic [CODE_BITS-1:0] code,
                                          input logic [ID_BITS-1:0] id);
        t_token t;
        t.cmd   = cmd;
        t.is_op = is_op;
        t.code  = code;
        t.id    = id;
        return t;
    endfunction

    task automatic queue_token(input t_token t);
        pend_q.push_back(t);
        if (t.cmd || !t.is_op || t.code < NUM_OPS) begin
            fed_count++;
        end
    endtask

    task automatic send_operand(input logic [ID_BITS-1:0] id);
        queue_token(make_token(1'b0, 1'b0, CODE_BITS'($urandom), id));
    endtask

    task automatic send_op(input logic [CODE_BITS-1:0] code);
        queue_token(make_token(1'b0, 1'b1, code, ID_BITS'($urandom)));
    endtask

    task automatic send_end();
        queue_token(make_token(1'b1, 1'($urandom), CODE_BITS'($urandom), ID_BITS'($urandom)));
    endtask

    // Well-formed expression with random content; now and then it is cut short
    task automatic gen_expression(input bit deep);
        int unsigned depth;
        int unsigned n;
        int unsigned lim;
        int unsigned r;
        bit          need_opd;
        bit          broken;
        depth    = 0;
        n        = 0;
        need_opd = 1'b1;
        broken   = 1'b0;
        lim      = $urandom_range(2, 14);
        // deep nesting to fill the stack past its end
        if (deep) begin
            repeat ($urandom_range(12, 20)) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_op(CODE_BITS'($urandom_range(FUNC_FIRST, FUNC_LAST)));
                end
                send_op(OP_LPAREN);
                depth++;
            end
        end
        while ((n < lim || need_opd || depth > 0) && !broken) begin
            if (need_opd) begin
                r = $urandom_range(0, 9);
                if (r < 5 || n >= lim) begin
                    send_operand(ID_BITS'($urandom));
                    need_opd = 1'b0;
                end else if (r < 7) begin
                    send_op(OP_LPAREN);
                    depth++;
                end else if (r < 9) begin
                    send_op(CODE_BITS'($urandom_range(FUNC_FIRST, FUNC_LAST)));
                    send_op(OP_LPAREN);
                    depth++;
                end else begin
                    // cast style prefix, still awaiting its operand
                    send_op(CODE_BITS'($urandom_range(FUNC_FIRST, FUNC_LAST)));
                end
            end else if (n >= lim) begin
                send_op(OP_RPAREN);
                depth--;
            end else begin
                r = $urandom_range(0, 9);
                if (depth > 0 && r < 2) begin
                    send_op(OP_RPAREN);
                    depth--;
                end else if (depth > 0 && r < 3) begin
                    send_op(OP_COMMA);
                    need_opd = 1'b1;
                end else begin
                    send_op(CODE_BITS'($urandom_range(OP_MUL, OP_SUB)));
                    need_opd = 1'b1;
                end
            end
            n++;
            broken = ($urandom_range(0, 39) == 0);
        end
        send_end();
    endtask

    // Mix of expressions, deep nests and raw random tokens until the fed count is reached
    task automatic run_random(input int unsigned goal);
        int unsigned r;
        while (fed_count < goal) begin
            r = $urandom_range(0, 19);
            if (r < 3) begin
                repeat ($urandom_range(1, 4)) begin
                    queue_token(make_token($urandom_range(0, 7) == 0, 1'($urandom),
                                           CODE_BITS'($urandom), ID_BITS'($urandom)));
                end
            end else begin
                gen_expression(r < 5);
            end
        end
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || postfix_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input logic [ID_BITS-1:0] want,
                               input logic [ID_BITS-1:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            end
        end
    endtask

    // Driver: offer the oldest pending token, predict it on acceptance
    always @(posedge i_clk) begin : token_driver
        t_token t;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                convert_token(pend_q.pop_front());
                if (idle_en && $urandom_range(0, 3) == 0) begin
                    tx_gap = $urandom_range(1, 13);
                end
            end
            if (tx_gap > 0) begin
                tx_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                t = pend_q[0];
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {{(IN_W - CODE_BITS - ID_BITS){1'b0}}, t.id, t.code};
                i_s_axis_tuser  <= {t.is_op, t.cmd};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat with the oldest prediction, throttle tready
    always @(posedge i_clk) begin : postfix_monitor
        t_beat want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rx_gap   = 0;
            hold_cnt = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (postfix_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("%0t: unexpected beat, expected none actual %h kind %h",
                                 $time, o_m_axis_tdata, o_m_axis_tuser);
                    end
                end else begin
                    want = postfix_q.pop_front();
                    check_field("kind", ID_BITS'(want.kind), ID_BITS'(o_m_axis_tuser));
                    check_field("operator", ID_BITS'(want.op),
                                ID_BITS'(o_m_axis_tdata[CODE_BITS-1:0]));
                    check_field("operand", want.id,
                                o_m_axis_tdata[CODE_BITS+ID_BITS-1:CODE_BITS]);
                    check_field("overflow", ID_BITS'(want.ovf),
                                ID_BITS'(o_m_axis_tdata[CODE_BITS+ID_BITS]));
                    check_field("last", ID_BITS'(want.last), ID_BITS'(o_m_axis_tlast));
                end
            end
            // long hold-off so the converter backs up onto its input
            if (hold_reqs != hold_done) begin
                hold_done = hold_reqs;
                hold_cnt  = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (idle_en && $urandom_range(0, 5) == 0) begin
                    rx_gap = $urandom_range(1, 13);
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty-stack corner cases and out-of-range codes
        send_op(OP_RPAREN);
        send_op(OP_COMMA);
        send_end();
        send_op(NUM_OPS);
        send_op(CODE_TOP);
        // f(lo, hi) * a / b % c + d - e , g )  with the final bracket unmatched
        send_op(FUNC_LAST);
        send_op(OP_LPAREN);
        send_operand('0);
        send_op(OP_COMMA);
        send_operand('1);
        send_op(OP_RPAREN);
        send_op(OP_MUL);
        send_operand(ID_BITS'($urandom));
        send_op(OP_DIV);
        send_operand(ID_BITS'($urandom));
        send_op(OP_MOD);
        send_operand(ID_BITS'($urandom));
        send_op(OP_ADD);
        send_operand(ID_BITS'($urandom));
        send_op(OP_SUB);
        send_operand(ID_BITS'($urandom));
        send_op(OP_COMMA);
        send_operand(ID_BITS'($urandom));
        send_op(OP_RPAREN);
        send_end();
        wait_drained();

        // random traffic, starting under a long receiver hold-off
        idle_en = 1'b1;
        hold_reqs++;
        run_random(80);
        // sender pauses until every result is back
        wait_drained();
        run_random(115);
        wait_drained();
        // closing stretch at full rate
        idle_en = 1'b0;
        run_random(140);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && postfix_q.size() == 0) begin
            $display("infix_to_postfix_converter_core_tb passed");
        end else begin
            $display("infix_to_postfix_converter_core_tb failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("infix_to_postfix_converter_core_tb failed");
        $finish;
    end

endmodule
